FILE: src/conditional_counter_update_defines.svh
// ----------------------------------------------------------------------------
// Conditional counter update: assertion macros
// Shared concurrent assertion forms, clocked, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CONDITIONAL_COUNTER_UPDATE_DEFINES_SVH
`define CONDITIONAL_COUNTER_UPDATE_DEFINES_SVH

// same-cycle implication
`define CCU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ccu_pkg.sv
// ----------------------------------------------------------------------------
// Conditional counter update package
// Field widths, operation and condition codes, control/status types.
// ----------------------------------------------------------------------------
package ccu_pkg;

  localparam int unsigned NUM_KEYS_DEF = 1024;
  localparam int unsigned KEY_W        = 10;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned CMP_W        = 3;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INC  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEC  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 3'd5;

  localparam logic [CMP_W-1:0] CMP_ALWAYS = 3'd0;
  localparam logic [CMP_W-1:0] CMP_EQ     = 3'd1;
  localparam logic [CMP_W-1:0] CMP_NEQ    = 3'd2;
  localparam logic [CMP_W-1:0] CMP_LT     = 3'd3;
  localparam logic [CMP_W-1:0] CMP_GT     = 3'd4;
  localparam logic [CMP_W-1:0] CMP_LE     = 3'd5;
  localparam logic [CMP_W-1:0] CMP_GE     = 3'd6;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic exec;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/ccu_if.sv
// ----------------------------------------------------------------------------
// Conditional counter update channels
// Instruction and result channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface ccu_req_if;
  logic                             valid;
  logic                             ready;
  logic [ccu_pkg::FUNC_W-1:0]       func;
  logic [ccu_pkg::CMP_W-1:0]        cmp_mode;
  logic [ccu_pkg::KEY_W-1:0]        target_key;
  logic                             operand_from_counter;
  logic [ccu_pkg::KEY_W-1:0]        operand_key;
  logic signed [ccu_pkg::DATA_W-1:0] operand_imm;

  modport source (
    output valid, func, cmp_mode, target_key, operand_from_counter, operand_key, operand_imm,
    input  ready
  );
  modport sink (
    input  valid, func, cmp_mode, target_key, operand_from_counter, operand_key, operand_imm,
    output ready
  );
endinterface

interface ccu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ccu_pkg::DATA_W-1:0] new_value;

  modport source (output valid, new_value, input ready);
  modport sink   (input valid, new_value, output ready);
endinterface

FILE: src/ccu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ccu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/ccu_ctrl.sv
// ----------------------------------------------------------------------------
// Conditional counter update controller
// Clear sweep after reset, then read / execute / write per instruction.
// ----------------------------------------------------------------------------
`include "conditional_counter_update_defines.svh"

module ccu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ccu_pkg::sts_t sts_i,
  output ccu_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    req_ready_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `CCU_ASSERT_SAME(a_commit_out_free, clk_i, rst_ni, cmd_o.commit, sts_i.out_free, "commit while result held")
  `CCU_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o, "second instruction taken while busy")
  `CCU_ASSERT_NEXT(a_clear_runs, clk_i, rst_ni, state_q == S_CLEAR && !sts_i.clr_last, state_q == S_CLEAR && !req_ready_o, "clear sweep cut short")

endmodule

FILE: src/ccu_dp.sv
// ----------------------------------------------------------------------------
// Conditional counter update datapath
// Counter RAM, operand select, compare, arithmetic and result register.
// ----------------------------------------------------------------------------
`include "conditional_counter_update_defines.svh"

module ccu_dp #(
  parameter int unsigned NUM_KEYS = ccu_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ccu_pkg::cmd_t                     cmd_i,
  output ccu_pkg::sts_t                     sts_o,
  input  logic [ccu_pkg::FUNC_W-1:0]        func_i,
  input  logic [ccu_pkg::CMP_W-1:0]         cmp_mode_i,
  input  logic [ccu_pkg::KEY_W-1:0]         target_key_i,
  input  logic                              operand_from_counter_i,
  input  logic [ccu_pkg::KEY_W-1:0]         operand_key_i,
  input  logic signed [ccu_pkg::DATA_W-1:0] operand_imm_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [ccu_pkg::DATA_W-1:0] new_value_o
);

  localparam int unsigned AW = $clog2(NUM_KEYS);
  localparam int unsigned DW = ccu_pkg::DATA_W;

  // captured instruction
  logic [ccu_pkg::FUNC_W-1:0] func_q;
  logic [ccu_pkg::CMP_W-1:0]  cmp_q;
  logic [AW-1:0]              tkey_q, okey_q;
  logic                       tok_q, ook_q, from_q;
  logic signed [DW-1:0]       imm_q;

  // execute stage
  logic signed [DW-1:0] a_q, opres_q;
  logic                 cond_q;

  logic [AW-1:0]        clr_cnt_q;
  logic                 out_valid_q;
  logic signed [DW-1:0] out_data_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata, rd_a, rd_b;
  logic signed [DW-1:0] a_val, b_val, opres, result;
  logic                 cond;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      cmp_q  <= cmp_mode_i;
      tkey_q <= AW'(target_key_i);
      okey_q <= AW'(operand_key_i);
      tok_q  <= 32'(target_key_i) < NUM_KEYS;
      ook_q  <= 32'(operand_key_i) < NUM_KEYS;
      from_q <= operand_from_counter_i;
      imm_q  <= operand_imm_i;
    end
    if (cmd_i.exec) begin
      a_q     <= a_val;
      opres_q <= opres;
      cond_q  <= cond;
    end
    if (cmd_i.commit) begin
      out_data_q <= result;
    end
  end

  ccu_ram #(
    .WIDTH(DW),
    .DEPTH(NUM_KEYS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(tkey_q),
    .rdata_a_o(rd_a),
    .raddr_b_i(okey_q),
    .rdata_b_o(rd_b)
  );

  // out-of-range keys read as zero
  assign a_val = tok_q ? $signed(rd_a) : '0;
  assign b_val = from_q ? (ook_q ? $signed(rd_b) : '0) : imm_q;

  always_comb begin
    case (cmp_q)
      ccu_pkg::CMP_EQ:  cond = a_val == b_val;
      ccu_pkg::CMP_NEQ: cond = a_val != b_val;
      ccu_pkg::CMP_LT:  cond = a_val < b_val;
      ccu_pkg::CMP_GT:  cond = a_val > b_val;
      ccu_pkg::CMP_LE:  cond = a_val <= b_val;
      ccu_pkg::CMP_GE:  cond = a_val >= b_val;
      default:          cond = 1'b1;
    endcase
  end

  always_comb begin
    case (func_q)
      ccu_pkg::FUNC_SET: opres = b_val;
      ccu_pkg::FUNC_INC: opres = a_val + DW'(1);
      ccu_pkg::FUNC_DEC: opres = a_val - DW'(1);
      ccu_pkg::FUNC_ADD: opres = a_val + b_val;
      ccu_pkg::FUNC_SUB: opres = a_val - b_val;
      default:           opres = a_val;
    endcase
  end

  assign result    = cond_q ? opres_q : a_q;
  assign ram_we    = cmd_i.clr_step || (cmd_i.commit && tok_q);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : tkey_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = clr_cnt_q == AW'(NUM_KEYS - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign new_value_o    = out_data_q;

  `CCU_ASSERT_SAME(a_rise_needs_commit, clk_i, rst_ni, $rose(out_valid_q), $past(cmd_i.commit), "result appeared without commit")
  `CCU_ASSERT_SAME(a_clear_excl, clk_i, rst_ni, cmd_i.clr_step, !cmd_i.commit && !cmd_i.capture, "instruction activity during clear")
  `CCU_ASSERT_NEXT(a_commit_loads, clk_i, rst_ni, cmd_i.commit, out_valid_q && new_value_o == $past(result), "result not loaded on commit")

endmodule

FILE: src/conditional_counter_update.sv
// An accepted instruction passes the read, execute and write states of the
// counter RAM in turn; no new instruction is taken until it is written, and the
// write waits while a finished result is held on the result channel.
// Reset: asynchronous; afterwards every counter RAM entry is swept to zero,
// during which no instruction is taken.
// ----------------------------------------------------------------------------
// Conditional counter update
// Table of signed 64-bit counters updated by conditional instructions.
// ----------------------------------------------------------------------------
module conditional_counter_update #(
  parameter int unsigned NUM_KEYS = ccu_pkg::NUM_KEYS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  ccu_req_if.sink    req_i,
  ccu_rsp_if.source  rsp_o
);

  ccu_pkg::cmd_t cmd;
  ccu_pkg::sts_t sts;

  ccu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccu_dp #(
    .NUM_KEYS(NUM_KEYS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .func_i                (req_i.func),
    .cmp_mode_i            (req_i.cmp_mode),
    .target_key_i          (req_i.target_key),
    .operand_from_counter_i(req_i.operand_from_counter),
    .operand_key_i         (req_i.operand_key),
    .operand_imm_i         (req_i.operand_imm),
    .out_ready_i           (rsp_o.ready),
    .out_valid_o           (rsp_o.valid),
    .new_value_o           (rsp_o.new_value)
  );

endmodule
